>>> rtl/gaussian_blur_downsample_5x5_top_macros.svh
// assertion macros for the gaussian blur downsampler checker
// used by gbd5_checker only; no other dependencies
`ifndef GAUSSIAN_BLUR_DOWNSAMPLE_5X5_TOP_MACROS_SVH
`define GAUSSIAN_BLUR_DOWNSAMPLE_5X5_TOP_MACROS_SVH

// plain clocked assertion, checked at every edge
`define GBD5_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

// clocked assertion, switched off while reset is high
`define GBD5_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

>>> rtl/gbd5_pkg.sv
// shared types, constants and helper functions of the gaussian blur downsampler
// no dependencies; used by the top level and its checker
package gbd5_pkg;

   // field widths
   localparam int PIX_W     = 16;
   localparam int COORD_W   = 10;
   localparam int IN_DIM_W  = 12;
   localparam int OUT_DIM_W = 11;
   localparam int CSR_W     = 12;
   localparam int CSR_IDX_W = 2;

   // one column sum of 5 weighted pixels, and the full 5x5 sum
   localparam int VSUM_W = 20;
   localparam int SUM_W  = 24;

   // binomial kernel
   localparam int TAPS = 5;
   localparam logic [2:0] TAP [TAPS] = '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1};

   // older rows kept per column in the line memory
   localparam int KEEP_ROWS = 4;

   // result queue
   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_AW    = 4;
   localparam int FIFO_CW    = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IN_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HEIGHT = 2'd3;

   // register reset values
   localparam logic [IN_DIM_W-1:0]  RST_IN_WIDTH   = 12'd640;
   localparam logic [IN_DIM_W-1:0]  RST_IN_HEIGHT  = 12'd480;
   localparam logic [OUT_DIM_W-1:0] RST_OUT_WIDTH  = 11'd320;
   localparam logic [OUT_DIM_W-1:0] RST_OUT_HEIGHT = 11'd240;

   typedef logic [KEEP_ROWS-1:0][PIX_W-1:0] col_word_type;
   typedef logic [TAPS-1:0][VSUM_W-1:0]     win_type;

   // per-pixel bookkeeping that travels down the pipeline
   // a = lower output index completing here, b = edge-clamped one
   typedef struct packed {
      logic               ya_v;
      logic               yb_v;
      logic               xa_v;
      logic               xb_v;
      logic               ya_lof;
      logic               yb_lof;
      logic               xa_lof;
      logic               xb_lof;
      logic [COORD_W-1:0] ya;
      logic [COORD_W-1:0] yb;
      logic [COORD_W-1:0] xa;
      logic [COORD_W-1:0] xb;
      logic               row_zero;
      logic               row_odd;
      logic               col_zero;
      logic               col_odd;
      logic [2:0]         n;
   } meta_type;

   typedef struct packed {
      logic [PIX_W-1:0]   value;
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic               last_in_item;
      logic               last_of_frame;
   } rsp_type;

   // weighted 5-tap sum; v[d] is the sample d steps back, taps past
   // the newest sample clamp to v[0], e is the distance of the window's far end
   function automatic logic [SUM_W-1:0] win_sum(input win_type v, input logic [2:0] e);
      logic [SUM_W-1:0] acc;
      logic [2:0]       d;
      acc = '0;
      for (int k = 0; k < TAPS; k++) begin
         d   = (e > 3'(k)) ? e - 3'(k) : 3'd0;
         acc = acc + SUM_W'(v[d]) * SUM_W'(TAP[k]);
      end
      return acc;
   endfunction

   // divide by 256, round half up
   function automatic logic [PIX_W-1:0] round_sum(input logic [SUM_W-1:0] s);
      return PIX_W'((s + SUM_W'(128)) >> 8);
   endfunction

endpackage

>>> rtl/gaussian_blur_downsample_5x5_top.sv
// gaussian pyramid downsampler: 5x5 binomial blur sampled at every second pixel
// depends on gbd5_pkg
//
// Input pixels come in raster order on req_* (valid/ready); each transfer
// moves one pixel. Output pixel (x,y) is the 5x5 binomial average centered
// on input (2x,2y), borders replicated, and leaves on rsp_* with its
// coordinates once its last input pixel has been taken; up to four results
// per pixel at the right and bottom edges, ordered by row then column.
// Throughput: one pixel per cycle while req_ready is high. A line memory
// of MAX_WIDTH words, each holding the four previous rows of one column,
// is read and written once per pixel; a result passes stage 1 and stage 2
// before it waits in a 16-entry queue; req_ready drops only when the
// queue plus the pixels still in the pipe could overflow it, so a stalled
// receiver backs up into req_ready and nothing is lost.
// Reset (synchronous) empties the pipe and the queue, puts the position at
// (0,0) and loads 640x480 in, 320x240 out. The line memory is not cleared:
// the first row of a frame replicates itself upward, so no clearing pass.
// csr_we writes register csr_index at once; write only while idle.
module gaussian_blur_downsample_5x5_top #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gbd5_pkg::PIX_W-1:0]        req_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gbd5_pkg::PIX_W-1:0]        rsp_value,
   output logic [gbd5_pkg::COORD_W-1:0]      rsp_out_x,
   output logic [gbd5_pkg::COORD_W-1:0]      rsp_out_y,
   output logic                              rsp_last_in_item,
   output logic                              rsp_last_of_frame,
   input  logic                              csr_we,
   input  logic [gbd5_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gbd5_pkg::CSR_W-1:0]        csr_wdata
);
   import gbd5_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = CW + 1;
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int HW = RW + 1;

   // configuration registers and their effective values
   logic [IN_DIM_W-1:0]  in_width_ff, in_width_in, in_height_ff, in_height_in;
   logic [OUT_DIM_W-1:0] out_width_ff, out_width_in, out_height_ff, out_height_in;
   logic [WW-1:0]        w_ff, w_in;
   logic [HW-1:0]        h_ff, h_in;
   logic [OUT_DIM_W-1:0] ow_ff, ow_in, oh_ff, oh_in;
   logic [31:0]          wlim, hlim;

   // input position
   logic [CW-1:0] col_ff, col_in, col0;
   logic [RW-1:0] row_ff, row_in, row0;
   logic          restart, col_end, row_end, accept;
   logic [CW-2:0] bx;
   logic [RW-2:0] by;
   logic [1:0]    nx, ny;
   meta_type      meta_in;

   // line memory and stage 1
   col_word_type  row_mem [MAX_WIDTH];
   col_word_type  rd_word_ff, fwd_word_ff, cur_word, new_word;
   logic          fwd_ff, fwd_in;
   logic          s1_valid_ff;
   logic [CW-1:0] s1_col_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   meta_type      s1_meta_ff;
   logic [TAPS-1:0][PIX_W-1:0] vcol;
   win_type       vwin;
   logic [VSUM_W-1:0] va_in, vb_in;
   logic [2:0]    s1_n;

   // stage 2
   logic          s2_valid_ff;
   meta_type      s2_meta_ff;
   logic [VSUM_W-1:0] va_ff, vb_ff;
   logic [KEEP_ROWS-1:0][VSUM_W-1:0] sha_ff, sha_in, shb_ff, shb_in;
   win_type       wa, wb;
   logic [2:0]    ex;
   logic [2:0]    s2_n;
   rsp_type       ent [4];
   logic [3:0]    ev;
   logic [3:0][1:0] off;

   // result queue
   rsp_type             rsp_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]  count_ff, count_in;
   logic                pop;
   rsp_type             head;

   // register writes, reset values included so the effective sizes follow
   always_comb begin
      in_width_in   = in_width_ff;
      in_height_in  = in_height_ff;
      out_width_in  = out_width_ff;
      out_height_in = out_height_ff;
      if (reset) begin
         in_width_in   = RST_IN_WIDTH;
         in_height_in  = RST_IN_HEIGHT;
         out_width_in  = RST_OUT_WIDTH;
         out_height_in = RST_OUT_HEIGHT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IN_WIDTH:   in_width_in   = csr_wdata[IN_DIM_W-1:0];
            CSR_IN_HEIGHT:  in_height_in  = csr_wdata[IN_DIM_W-1:0];
            CSR_OUT_WIDTH:  out_width_in  = csr_wdata[OUT_DIM_W-1:0];
            CSR_OUT_HEIGHT: out_height_in = csr_wdata[OUT_DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // effective sizes: zero reads as one, large inputs clamp, outputs fit the input
   always_comb begin
      if (in_width_in == '0) begin
         w_in = WW'(1);
      end else if (32'(in_width_in) > 32'(MAX_WIDTH)) begin
         w_in = WW'(MAX_WIDTH);
      end else begin
         w_in = WW'(in_width_in);
      end
      if (in_height_in == '0) begin
         h_in = HW'(1);
      end else if (32'(in_height_in) > 32'(MAX_HEIGHT)) begin
         h_in = HW'(MAX_HEIGHT);
      end else begin
         h_in = HW'(in_height_in);
      end
      wlim  = (32'(w_in) + 32'd1) >> 1;
      hlim  = (32'(h_in) + 32'd1) >> 1;
      ow_in = (32'(out_width_in) < wlim) ? out_width_in : OUT_DIM_W'(wlim);
      oh_in = (32'(out_height_in) < hlim) ? out_height_in : OUT_DIM_W'(hlim);
   end

   always_ff @(posedge clock) begin
      in_width_ff   <= in_width_in;
      in_height_ff  <= in_height_in;
      out_width_ff  <= out_width_in;
      out_height_ff <= out_height_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      ow_ff         <= ow_in;
      oh_ff         <= oh_in;
   end

   // queue room for everything in flight plus a full burst
   always_comb begin
      s1_n      = s1_valid_ff ? s1_meta_ff.n : 3'd0;
      s2_n      = s2_valid_ff ? s2_meta_ff.n : 3'd0;
      req_ready = (6'(count_ff) + 6'(s1_n) + 6'(s2_n) + 6'd4) <= 6'(FIFO_DEPTH);
      accept    = req_valid && req_ready;
   end

   // position and which outputs this pixel completes
   always_comb begin
      restart = ({1'b0, col_ff} >= w_ff) || ({1'b0, row_ff} >= h_ff);
      col0    = restart ? '0 : col_ff;
      row0    = restart ? '0 : row_ff;
      col_end = ({1'b0, col0} + WW'(1)) == w_ff;
      row_end = ({1'b0, row0} + HW'(1)) == h_ff;
      bx      = col0[CW-1:1];
      by      = row0[RW-1:1];

      meta_in.xa_v   = !col0[0] && (bx != '0) && (32'(bx) <= 32'(ow_ff));
      meta_in.xb_v   = col_end && (32'(bx) < 32'(ow_ff));
      meta_in.xa     = COORD_W'(32'(bx) - 32'd1);
      meta_in.xb     = COORD_W'(bx);
      meta_in.xa_lof = 32'(bx) == 32'(ow_ff);
      meta_in.xb_lof = (32'(bx) + 32'd1) == 32'(ow_ff);

      meta_in.ya_v   = !row0[0] && (by != '0) && (32'(by) <= 32'(oh_ff));
      meta_in.yb_v   = row_end && (32'(by) < 32'(oh_ff));
      meta_in.ya     = COORD_W'(32'(by) - 32'd1);
      meta_in.yb     = COORD_W'(by);
      meta_in.ya_lof = 32'(by) == 32'(oh_ff);
      meta_in.yb_lof = (32'(by) + 32'd1) == 32'(oh_ff);

      meta_in.row_zero = row0 == '0;
      meta_in.row_odd  = row0[0];
      meta_in.col_zero = col0 == '0;
      meta_in.col_odd  = col0[0];

      nx        = 2'(meta_in.xa_v) + 2'(meta_in.xb_v);
      ny        = 2'(meta_in.ya_v) + 2'(meta_in.yb_v);
      meta_in.n = 3'(nx * ny);

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         col_in = col_end ? '0 : col0 + CW'(1);
         row_in = col_end ? (row_end ? '0 : row0 + RW'(1)) : row0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line memory: read at transfer, written back in the following cycle
   assign fwd_in = s1_valid_ff && (s1_col_ff == col0);

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_word_ff  <= row_mem[col0];
         fwd_ff      <= fwd_in;
         fwd_word_ff <= new_word;
      end
      if (s1_valid_ff) begin
         row_mem[s1_col_ff] <= new_word;
      end
   end

   // stage 1 control and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_col_ff  <= col0;
         s1_pix_ff  <= req_pixel;
         s1_meta_ff <= meta_in;
      end
   end

   // column of five rows; the top row of a frame replicates upward
   always_comb begin
      cur_word = fwd_ff ? fwd_word_ff : rd_word_ff;
      vcol[0]  = s1_pix_ff;
      for (int i = 0; i < KEEP_ROWS; i++) begin
         vcol[i+1] = s1_meta_ff.row_zero ? s1_pix_ff : cur_word[i];
      end
      for (int i = 0; i < KEEP_ROWS; i++) begin
         new_word[i] = vcol[i];
      end
      for (int i = 0; i < TAPS; i++) begin
         vwin[i] = VSUM_W'(vcol[i]);
      end
      va_in = VSUM_W'(win_sum(vwin, 3'd4));
      vb_in = VSUM_W'(win_sum(vwin, 3'd2 + 3'(s1_meta_ff.row_odd)));
   end

   // stage 2 registers and the horizontal history of column sums
   always_comb begin
      sha_in[0] = va_ff;
      shb_in[0] = vb_ff;
      for (int i = 1; i < KEEP_ROWS; i++) begin
         sha_in[i] = s2_meta_ff.col_zero ? va_ff : sha_ff[i-1];
         shb_in[i] = s2_meta_ff.col_zero ? vb_ff : shb_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         va_ff      <= va_in;
         vb_ff      <= vb_in;
         s2_meta_ff <= s1_meta_ff;
      end
      if (s2_valid_ff) begin
         sha_ff <= sha_in;
         shb_ff <= shb_in;
      end
   end

   // horizontal sums for up to four outputs, compacted in row-major order
   always_comb begin
      wa[0] = va_ff;
      wb[0] = vb_ff;
      for (int i = 1; i < TAPS; i++) begin
         wa[i] = s2_meta_ff.col_zero ? va_ff : sha_ff[i-1];
         wb[i] = s2_meta_ff.col_zero ? vb_ff : shb_ff[i-1];
      end
      ex = 3'd2 + 3'(s2_meta_ff.col_odd);

      ent[0].value = round_sum(win_sum(wa, 3'd4));
      ent[0].out_x = s2_meta_ff.xa;
      ent[0].out_y = s2_meta_ff.ya;
      ent[0].last_of_frame = s2_meta_ff.xa_lof && s2_meta_ff.ya_lof;
      ent[1].value = round_sum(win_sum(wa, ex));
      ent[1].out_x = s2_meta_ff.xb;
      ent[1].out_y = s2_meta_ff.ya;
      ent[1].last_of_frame = s2_meta_ff.xb_lof && s2_meta_ff.ya_lof;
      ent[2].value = round_sum(win_sum(wb, 3'd4));
      ent[2].out_x = s2_meta_ff.xa;
      ent[2].out_y = s2_meta_ff.yb;
      ent[2].last_of_frame = s2_meta_ff.xa_lof && s2_meta_ff.yb_lof;
      ent[3].value = round_sum(win_sum(wb, ex));
      ent[3].out_x = s2_meta_ff.xb;
      ent[3].out_y = s2_meta_ff.yb;
      ent[3].last_of_frame = s2_meta_ff.xb_lof && s2_meta_ff.yb_lof;

      ev[0] = s2_meta_ff.ya_v && s2_meta_ff.xa_v;
      ev[1] = s2_meta_ff.ya_v && s2_meta_ff.xb_v;
      ev[2] = s2_meta_ff.yb_v && s2_meta_ff.xa_v;
      ev[3] = s2_meta_ff.yb_v && s2_meta_ff.xb_v;

      ent[0].last_in_item = ev[0] && (ev[3:1] == '0);
      ent[1].last_in_item = ev[1] && (ev[3:2] == '0);
      ent[2].last_in_item = ev[2] && !ev[3];
      ent[3].last_in_item = ev[3];

      off[0] = 2'd0;
      off[1] = 2'(ev[0]);
      off[2] = 2'(ev[0]) + 2'(ev[1]);
      off[3] = 2'(ev[0]) + 2'(ev[1]) + 2'(ev[2]);
   end

   // result queue storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (s2_valid_ff && ev[i]) begin
            rsp_mem[wr_ptr_ff + FIFO_AW'(off[i])] <= ent[i];
         end
      end
   end

   // result queue pointers and fill level
   always_comb begin
      pop       = rsp_valid && rsp_ready;
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(s2_n);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + FIFO_CW'(s2_n) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // head of the queue drives the result channel
   always_comb begin
      head              = rsp_mem[rd_ptr_ff];
      rsp_valid         = count_ff != '0;
      rsp_value         = head.value;
      rsp_out_x         = head.out_x;
      rsp_out_y         = head.out_y;
      rsp_last_in_item  = head.last_in_item;
      rsp_last_of_frame = head.last_of_frame;
   end

endmodule

>>> rtl/gbd5_checker.sv
// port-level checks for the gaussian blur downsampler, bound to the top level
// depends on gbd5_pkg and gaussian_blur_downsample_5x5_top_macros.svh
`include "gaussian_blur_downsample_5x5_top_macros.svh"

module gbd5_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [gbd5_pkg::PIX_W-1:0]     rsp_value,
   input logic [gbd5_pkg::COORD_W-1:0]   rsp_out_x,
   input logic [gbd5_pkg::COORD_W-1:0]   rsp_out_y,
   input logic                           rsp_last_in_item,
   input logic                           rsp_last_of_frame
);

   // a stalled result keeps its whole payload
   `GBD5_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_last_in_item) && $stable(rsp_last_of_frame), "result changed while stalled")

   // reset empties the result queue
   `GBD5_ASSERT(a_rst_empty, clock, reset |=> !rsp_valid, "result valid right after reset")

   // with nothing in flight the input side is open
   `GBD5_ASSERT(a_rst_ready, clock, reset |=> req_ready, "input not ready right after reset")

   // the frame's final output is always the last one of its pixel
   `GBD5_ASSERT_RST(a_lof_last, clock, reset, rsp_valid && rsp_last_of_frame |-> rsp_last_in_item, "frame end not marked as last of its pixel")

endmodule

bind gaussian_blur_downsample_5x5_top gbd5_checker u_gbd5_checker (.*);
